[sv/adsr_pkg.sv]
// Shared types and constants for the ADSR envelope generator.
// Used by the top level, the sample step datapath and the port checker.
`default_nettype none

package adsr_pkg;

  // Default number of fraction bits; 1.0 is 2**FRAC_BITS.
  localparam int unsigned FRAC_BITS_DEF = 24;

  // Configuration port geometry: five registers at byte addresses 4*i.
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ATTACK_STEP    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DECAY_FACTOR   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SUSTAIN_LEVEL  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE_FACTOR = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KILL_STEP      = 3'd4;

  // Envelope stages as they appear on the phase output.
  typedef enum logic [1:0] {
    PH_RELEASE = 2'd0,
    PH_DECAY   = 2'd1,
    PH_ATTACK  = 2'd2,
    PH_KILL    = 2'd3
  } phase_e;

  // Voice events that come with a sample item.
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_ON    = 3'd1,
    EV_OFF   = 3'd2,
    EV_RESET = 3'd3,
    EV_KILL  = 3'd4
  } event_e;

  // Current stage and the stage entered once a kill ramp ends.
  typedef struct packed {
    phase_e env;
    phase_e queued;
  } phase_state_t;

endpackage

`default_nettype wire

[sv/adsr_envelope_generator.sv]
// Top level of the ADSR envelope generator: configuration registers,
// input and result registers, envelope state. Depends on adsr_pkg, adsr_step.
`default_nettype none

// The block takes one sample item per clock cycle while in_stall_o is low, each
// carrying an optional voice event, and returns one result item (level, phase,
// finished) per sample. An item passes through the input register and then the
// result register; the event decode, the single level multiply and
// the stage update sit between them, and the envelope state is updated as an
// item moves on. With the result side never stalling, one item is accepted
// and one delivered every cycle. Levels are unsigned with 1.0 = 2**FRAC_BITS.
// The configuration registers sit on an APB-style port at byte address 4*i
// and should be written while no items are in flight.
module adsr_envelope_generator #(
  parameter int unsigned FRAC_BITS = adsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Sample items in
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [2:0]                  voice_event_i,
  // Result items out
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [FRAC_BITS:0]               level_o,
  output logic [1:0]                       phase_o,
  output logic                             finished_o,
  // Configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [adsr_pkg::APB_AW-1:0] paddr,
  input  wire logic [adsr_pkg::APB_DW-1:0] pwdata,
  output logic [adsr_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  localparam int unsigned LVL_W = FRAC_BITS + 1;

  logic [LVL_W-1:0]     attack_step_q;
  logic [FRAC_BITS-1:0] decay_factor_q;
  logic [LVL_W-1:0]     sustain_level_q;
  logic [FRAC_BITS-1:0] release_factor_q;
  logic [LVL_W-1:0]     kill_step_q;

  logic                        cfg_wr;
  logic [adsr_pkg::REG_IDX_W-1:0] cfg_idx;

  logic       ev_valid_q;
  logic       ev_valid_d;
  logic [2:0] ev_q;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       out_free;
  logic       advance;

  adsr_pkg::phase_state_t state_q;
  adsr_pkg::phase_state_t state_d;
  logic [LVL_W-1:0]       level_q;
  logic [LVL_W-1:0]       level_d;
  logic                   fin_d;

  logic [LVL_W-1:0] res_level_q;
  adsr_pkg::phase_e res_phase_q;
  logic             res_fin_q;

  // Configuration writes complete in the access cycle; no wait states.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[adsr_pkg::APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_step_q    <= '0;
      decay_factor_q   <= '0;
      sustain_level_q  <= '0;
      release_factor_q <= '0;
      kill_step_q      <= LVL_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        adsr_pkg::REG_ATTACK_STEP:    attack_step_q    <= pwdata[LVL_W-1:0];
        adsr_pkg::REG_DECAY_FACTOR:   decay_factor_q   <= pwdata[FRAC_BITS-1:0];
        adsr_pkg::REG_SUSTAIN_LEVEL:  sustain_level_q  <= pwdata[LVL_W-1:0];
        adsr_pkg::REG_RELEASE_FACTOR: release_factor_q <= pwdata[FRAC_BITS-1:0];
        adsr_pkg::REG_KILL_STEP:      kill_step_q      <= pwdata[LVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back; addresses past the list read as zero.
  always_comb begin
    unique case (cfg_idx)
      adsr_pkg::REG_ATTACK_STEP:    prdata = adsr_pkg::APB_DW'(attack_step_q);
      adsr_pkg::REG_DECAY_FACTOR:   prdata = adsr_pkg::APB_DW'(decay_factor_q);
      adsr_pkg::REG_SUSTAIN_LEVEL:  prdata = adsr_pkg::APB_DW'(sustain_level_q);
      adsr_pkg::REG_RELEASE_FACTOR: prdata = adsr_pkg::APB_DW'(release_factor_q);
      adsr_pkg::REG_KILL_STEP:      prdata = adsr_pkg::APB_DW'(kill_step_q);
      default:                      prdata = '0;
    endcase
  end

  // Handshake: the input register moves on whenever the result register
  // is empty or is being emptied this cycle.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = ev_valid_q && out_free;
  assign in_stall_o  = ev_valid_q && !out_free;
  assign ev_valid_d  = in_stall_o ? 1'b1 : in_valid_i;
  assign out_valid_d = out_free ? ev_valid_q : 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ev_valid_q  <= ev_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register for the event of the waiting item.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ev_q <= voice_event_i;
    end
  end

  adsr_step #(
    .FRAC_BITS(FRAC_BITS)
  ) u_step (
    .voice_event_i   (ev_q),
    .state_i         (state_q),
    .level_i         (level_q),
    .attack_step_i   (attack_step_q),
    .decay_factor_i  (decay_factor_q),
    .sustain_level_i (sustain_level_q),
    .release_factor_i(release_factor_q),
    .kill_step_i     (kill_step_q),
    .state_o         (state_d),
    .level_o         (level_d),
    .finished_o      (fin_d)
  );

  // Envelope state advances once per item, in order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{env: adsr_pkg::PH_RELEASE, queued: adsr_pkg::PH_RELEASE};
      level_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
      level_q <= level_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_level_q <= level_d;
      res_phase_q <= state_d.env;
      res_fin_q   <= fin_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = res_level_q;
  assign phase_o     = res_phase_q;
  assign finished_o  = res_fin_q;

endmodule

`default_nettype wire

[sv/adsr_step.sv]
// Combinational datapath for one envelope sample: applies the voice event,
// then advances the level by one sample. Depends on adsr_pkg.
`default_nettype none

module adsr_step #(
  parameter int unsigned FRAC_BITS = adsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic [2:0]           voice_event_i,
  input  wire adsr_pkg::phase_state_t state_i,
  input  wire logic [FRAC_BITS:0]   level_i,
  input  wire logic [FRAC_BITS:0]   attack_step_i,
  input  wire logic [FRAC_BITS-1:0] decay_factor_i,
  input  wire logic [FRAC_BITS:0]   sustain_level_i,
  input  wire logic [FRAC_BITS-1:0] release_factor_i,
  input  wire logic [FRAC_BITS:0]   kill_step_i,
  output adsr_pkg::phase_state_t    state_o,
  output logic [FRAC_BITS:0]        level_o,
  output logic                      finished_o
);

  localparam int unsigned LVL_W = FRAC_BITS + 1;
  localparam int unsigned PROD_W = LVL_W + FRAC_BITS;
  localparam logic [LVL_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [LVL_W:0] ATTACK_DONE_Q =
    (LVL_W+1)'(((64'd1 << FRAC_BITS) * 64'd999) / 64'd1000);

  adsr_pkg::phase_state_t st;
  logic [LVL_W-1:0]  lv;
  logic              above;
  logic [LVL_W-1:0]  diff;
  logic [LVL_W-1:0]  mul_a;
  logic [FRAC_BITS-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic [LVL_W-1:0]  scaled;
  logic [LVL_W:0]    attack_sum;

  // The voice event acts on the stage registers before the sample update.
  always_comb begin
    st = state_i;
    lv = level_i;
    unique case (adsr_pkg::event_e'(voice_event_i))
      adsr_pkg::EV_ON: begin
        st.env    = adsr_pkg::PH_KILL;
        st.queued = adsr_pkg::PH_ATTACK;
      end
      adsr_pkg::EV_OFF: begin
        if (state_i.env == adsr_pkg::PH_KILL) begin
          st.queued = adsr_pkg::PH_RELEASE;
        end else begin
          st.env = adsr_pkg::PH_RELEASE;
        end
      end
      adsr_pkg::EV_RESET: begin
        st.env = adsr_pkg::PH_ATTACK;
        lv     = '0;
      end
      adsr_pkg::EV_KILL: begin
        st.env    = adsr_pkg::PH_KILL;
        st.queued = adsr_pkg::PH_RELEASE;
      end
      default: begin
      end
    endcase
  end

  // One multiplier serves both release scaling and the decay distance.
  assign above  = (lv >= sustain_level_i);
  assign diff   = above ? (lv - sustain_level_i) : (sustain_level_i - lv);
  assign mul_a  = (st.env == adsr_pkg::PH_RELEASE) ? lv : diff;
  assign mul_b  = (st.env == adsr_pkg::PH_RELEASE) ? release_factor_i : decay_factor_i;
  assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign scaled = prod[PROD_W-1:FRAC_BITS];
  assign attack_sum = {1'b0, lv} + {1'b0, attack_step_i};

  // Per-stage sample update.
  always_comb begin
    state_o    = st;
    level_o    = lv;
    finished_o = 1'b0;
    unique case (st.env)
      adsr_pkg::PH_RELEASE: begin
        level_o = scaled;
      end
      adsr_pkg::PH_DECAY: begin
        // The scaled distance is never larger than the distance itself,
        // so the level moves toward sustain and never overshoots.
        level_o = above ? (sustain_level_i + scaled) : (sustain_level_i - scaled);
      end
      adsr_pkg::PH_ATTACK: begin
        if ((attack_step_i == '0) || (attack_sum > ATTACK_DONE_Q)) begin
          level_o     = ONE_Q;
          state_o.env = adsr_pkg::PH_DECAY;
        end else begin
          level_o = attack_sum[LVL_W-1:0];
        end
      end
      adsr_pkg::PH_KILL: begin
        if (lv <= kill_step_i) begin
          level_o     = '0;
          finished_o  = 1'b1;
          state_o.env = st.queued;
        end else begin
          level_o = lv - kill_step_i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/adsr_checker.sv]
// Port-level checks for the ADSR envelope generator, with the bind that
// attaches them to the top level. Depends on adsr_pkg.
`default_nettype none

module adsr_checker #(
  parameter int unsigned FRAC_BITS = adsr_pkg::FRAC_BITS_DEF
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [FRAC_BITS:0] level_o,
  input wire logic [1:0]         phase_o,
  input wire logic               finished_o,
  input wire logic               pready
);

  localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  // A result held under stall keeps its level.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(level_o))
    else $error("stalled result changed");

  // The end of a kill ramp reports a zero level.
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> level_o == '0)
    else $error("finished with nonzero level");

  // A kill ramp only ever hands over to release or attack.
  a_fin_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |->
      phase_o == adsr_pkg::PH_RELEASE || phase_o == adsr_pkg::PH_ATTACK)
    else $error("kill ramp ended in an unexpected stage");

  // Reaching full scale always ends the attack stage.
  a_attack_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == adsr_pkg::PH_ATTACK |-> level_o < ONE_Q)
    else $error("attack stage at full scale");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind adsr_envelope_generator adsr_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_adsr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .level_o    (level_o),
  .phase_o    (phase_o),
  .finished_o (finished_o),
  .pready     (pready)
);

`default_nettype wire
